[rtl/eba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eight-bit ALU package
// Operation codes and the request and result records shared by the ALU files.
// ----------------------------------------------------------------------------
package eba_pkg;

  typedef enum logic [3:0] {
    MODE_ADC = 4'd0,
    MODE_SBC = 4'd1,
    MODE_AND = 4'd2,
    MODE_ORA = 4'd3,
    MODE_EOR = 4'd4,
    MODE_CMP = 4'd5,
    MODE_ASL = 4'd6,
    MODE_LSR = 4'd7,
    MODE_ROL = 4'd8,
    MODE_ROR = 4'd9
  } alu_mode_e;

  localparam int unsigned DataWidth = 8;
  localparam int unsigned ModeWidth = 4;

  typedef struct packed {
    logic [ModeWidth-1:0] mode;
    logic [DataWidth-1:0] acc;
    logic [DataWidth-1:0] operand;
    logic                 carry;
    logic                 overflow;
    logic                 zero;
    logic                 negative;
    logic                 decimal;
  } alu_req_t;

  typedef struct packed {
    logic [DataWidth-1:0] result;
    logic                 carry;
    logic                 overflow;
    logic                 zero;
    logic                 negative;
    logic                 unsupported;
  } alu_rsp_t;

endpackage

[rtl/eba_reg_slice.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipeline register slice
// One valid/stall register stage that accepts a new request whenever its
// contents are empty or are being taken in the same cycle.
// ----------------------------------------------------------------------------
module eba_reg_slice #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q;
  logic [Width-1:0] data_q;
  logic             advance;

  assign advance = !valid_q || !stall_i;
  assign stall_o = !advance;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

[rtl/eba_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eight-bit ALU datapath
// Computes the new value, the N, Z, C and V flags and the unsupported flag for one request.
// ----------------------------------------------------------------------------
module eba_alu (
  input  eba_pkg::alu_req_t req_i,
  output eba_pkg::alu_rsp_t rsp_o
);
  import eba_pkg::*;

  logic [DataWidth-1:0] addend;
  logic [DataWidth:0]   sum;
  logic [DataWidth:0]   diff;
  logic [DataWidth-1:0] res;
  logic                 set_zn;

  assign addend = (alu_mode_e'(req_i.mode) == MODE_SBC) ? ~req_i.operand : req_i.operand;
  assign sum    = {1'b0, req_i.acc} + {1'b0, addend} + {{DataWidth{1'b0}}, req_i.carry};
  assign diff   = {1'b0, req_i.acc} - {1'b0, req_i.operand};

  always_comb begin
    rsp_o             = '0;
    rsp_o.result      = req_i.acc;
    rsp_o.carry       = req_i.carry;
    rsp_o.overflow    = req_i.overflow;
    rsp_o.zero        = req_i.zero;
    rsp_o.negative    = req_i.negative;
    rsp_o.unsupported = 1'b0;
    res               = req_i.acc;
    set_zn            = 1'b1;
    case (alu_mode_e'(req_i.mode))
      MODE_ADC, MODE_SBC: begin
        if (req_i.decimal) begin
          rsp_o.unsupported = 1'b1;
          set_zn            = 1'b0;
        end else begin
          res            = sum[DataWidth-1:0];
          rsp_o.carry    = sum[DataWidth];
          rsp_o.overflow = ~(req_i.acc[DataWidth-1] ^ addend[DataWidth-1]) &
                           (sum[DataWidth-1] ^ addend[DataWidth-1]);
        end
      end
      MODE_AND: res = req_i.acc & req_i.operand;
      MODE_ORA: res = req_i.acc | req_i.operand;
      MODE_EOR: res = req_i.acc ^ req_i.operand;
      MODE_CMP: begin
        set_zn         = 1'b0;
        rsp_o.negative = diff[DataWidth-1];
        rsp_o.zero     = (req_i.acc == req_i.operand);
        rsp_o.carry    = !diff[DataWidth];
      end
      MODE_ASL: begin
        res         = {req_i.operand[DataWidth-2:0], 1'b0};
        rsp_o.carry = req_i.operand[DataWidth-1];
      end
      MODE_LSR: begin
        res         = {1'b0, req_i.operand[DataWidth-1:1]};
        rsp_o.carry = req_i.operand[0];
      end
      MODE_ROL: begin
        res         = {req_i.operand[DataWidth-2:0], req_i.carry};
        rsp_o.carry = req_i.operand[DataWidth-1];
      end
      MODE_ROR: begin
        res         = {req_i.carry, req_i.operand[DataWidth-1:1]};
        rsp_o.carry = req_i.operand[0];
      end
      default: set_zn = 1'b0;
    endcase
    rsp_o.result = res;
    if (set_zn) begin
      rsp_o.zero     = (res == '0);
      rsp_o.negative = res[DataWidth-1];
    end
  end

endmodule

[rtl/eight_bit_alu_with_flags.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eight-bit ALU with flags
// Registered request stage, single-pass ALU datapath and registered result
// stage for an eight-bit processor ALU.
// ----------------------------------------------------------------------------
//   Channel  Handshake                  Payload
//   input    in_valid_i / in_stall_o    mode, acc, operand, incoming flags
//   output   out_valid_o / out_stall_i  result, new flags, unsupported
//
// A request is registered, passes through the combinational ALU logic and is
// registered again in the result stage, from which its result is offered.
// One request is accepted every cycle while the output does not stall.
// Reset empties both stages. A stall on the output holds the result stage and
// backs up into the request stage, which raises in_stall_o only when full.
module eight_bit_alu_with_flags (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] mode_i,
  input  logic [7:0] acc_i,
  input  logic [7:0] operand_i,
  input  logic       carry_in_i,
  input  logic       overflow_in_i,
  input  logic       zero_in_i,
  input  logic       negative_in_i,
  input  logic       decimal_mode_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] result_o,
  output logic       carry_out_o,
  output logic       overflow_out_o,
  output logic       zero_out_o,
  output logic       negative_out_o,
  output logic       unsupported_o
);
  import eba_pkg::*;

  alu_req_t req_in;
  alu_req_t req_reg;
  alu_rsp_t rsp_comb;
  alu_rsp_t rsp_reg;
  logic     req_valid;
  logic     req_stall;

  assign req_in.mode     = mode_i;
  assign req_in.acc      = acc_i;
  assign req_in.operand  = operand_i;
  assign req_in.carry    = carry_in_i;
  assign req_in.overflow = overflow_in_i;
  assign req_in.zero     = zero_in_i;
  assign req_in.negative = negative_in_i;
  assign req_in.decimal  = decimal_mode_i;

  eba_reg_slice #(
    .Width($bits(alu_req_t))
  ) u_req_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .stall_o(in_stall_o),
    .data_i (req_in),
    .valid_o(req_valid),
    .stall_i(req_stall),
    .data_o (req_reg)
  );

  eba_alu u_alu (
    .req_i(req_reg),
    .rsp_o(rsp_comb)
  );

  eba_reg_slice #(
    .Width($bits(alu_rsp_t))
  ) u_rsp_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(req_valid),
    .stall_o(req_stall),
    .data_i (rsp_comb),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (rsp_reg)
  );

  assign result_o       = rsp_reg.result;
  assign carry_out_o    = rsp_reg.carry;
  assign overflow_out_o = rsp_reg.overflow;
  assign zero_out_o     = rsp_reg.zero;
  assign negative_out_o = rsp_reg.negative;
  assign unsupported_o  = rsp_reg.unsupported;

endmodule

[test/eight_bit_alu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eight-bit ALU result checker
// Watches both channels of the ALU. For every accepted request it works out
// the new value and flags and queues them. Every accepted result is compared
// field by field with the oldest queued outcome.
// ----------------------------------------------------------------------------
module eight_bit_alu_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [3:0] mode_i,
  input  logic [7:0] acc_i,
  input  logic [7:0] operand_i,
  input  logic       carry_in_i,
  input  logic       overflow_in_i,
  input  logic       zero_in_i,
  input  logic       negative_in_i,
  input  logic       decimal_mode_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] result_i,
  input  logic       carry_out_i,
  input  logic       overflow_out_i,
  input  logic       zero_out_i,
  input  logic       negative_out_i,
  input  logic       unsupported_i,
  output int         fail_count_o,
  output int         pending_o
);
  import eba_pkg::*;

  alu_req_t req_now;
  alu_rsp_t rsp_now;
  alu_rsp_t want;
  alu_rsp_t outcome_q[$];
  int       mismatches = 0;
  int       outstanding = 0;

  assign req_now = {mode_i, acc_i, operand_i, carry_in_i, overflow_in_i, zero_in_i,
                    negative_in_i, decimal_mode_i};
  assign rsp_now = {result_i, carry_out_i, overflow_out_i, zero_out_i, negative_out_i,
                    unsupported_i};
  assign fail_count_o = mismatches;
  assign pending_o = outstanding;

  function automatic alu_rsp_t alu_outcome(alu_req_t req);
    alu_rsp_t   rsp;
    logic [7:0] addend;
    logic [7:0] diff;
    logic [8:0] sum;
    logic       touch_zn;
    rsp.result = req.acc;
    rsp.carry = req.carry;
    rsp.overflow = req.overflow;
    rsp.zero = req.zero;
    rsp.negative = req.negative;
    rsp.unsupported = 1'b0;
    touch_zn = 1'b1;
    case (req.mode)
      MODE_ADC, MODE_SBC: begin
        if (req.decimal) begin
          rsp.unsupported = 1'b1;
          touch_zn = 1'b0;
        end else begin
          addend = (req.mode == MODE_SBC) ? ~req.operand : req.operand;
          sum = {1'b0, req.acc} + {1'b0, addend} + {8'd0, req.carry};
          rsp.result = sum[7:0];
          rsp.carry = sum[8];
          rsp.overflow = ~(req.acc[7] ^ addend[7]) & (sum[7] ^ addend[7]);
        end
      end
      MODE_AND: rsp.result = req.acc & req.operand;
      MODE_ORA: rsp.result = req.acc | req.operand;
      MODE_EOR: rsp.result = req.acc ^ req.operand;
      MODE_CMP: begin
        diff = req.acc - req.operand;
        rsp.negative = diff[7];
        rsp.zero = (req.acc == req.operand);
        rsp.carry = (req.acc >= req.operand);
        touch_zn = 1'b0;
      end
      MODE_ASL: begin
        rsp.result = {req.operand[6:0], 1'b0};
        rsp.carry = req.operand[7];
      end
      MODE_LSR: begin
        rsp.result = {1'b0, req.operand[7:1]};
        rsp.carry = req.operand[0];
      end
      MODE_ROL: begin
        rsp.result = {req.operand[6:0], req.carry};
        rsp.carry = req.operand[7];
      end
      MODE_ROR: begin
        rsp.result = {req.carry, req.operand[7:1]};
        rsp.carry = req.operand[0];
      end
      default: touch_zn = 1'b0;
    endcase
    if (touch_zn) begin
      rsp.zero = (rsp.result == 8'd0);
      rsp.negative = rsp.result[7];
    end
    return rsp;
  endfunction

  task automatic check_field(string name, logic [7:0] expected, logic [7:0] actual);
    if (expected !== actual) begin
      $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
      mismatches++;
    end
  endtask

  // A result is taken before the request of the same edge is queued, so a
  // result with nothing outstanding is never matched with a fresh request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outcome_q.delete();
      outstanding = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          $error("result %0h arrived with no request outstanding", result_i);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          check_field("result", want.result, rsp_now.result);
          check_field("carry_out", 8'(want.carry), 8'(rsp_now.carry));
          check_field("overflow_out", 8'(want.overflow), 8'(rsp_now.overflow));
          check_field("zero_out", 8'(want.zero), 8'(rsp_now.zero));
          check_field("negative_out", 8'(want.negative), 8'(rsp_now.negative));
          check_field("unsupported", 8'(want.unsupported), 8'(rsp_now.unsupported));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        outcome_q.push_back(alu_outcome(req_now));
      end
      outstanding = outcome_q.size();
    end
  end

endmodule

[test/tb_eight_bit_alu_with_flags.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eight-bit ALU with flags testbench
// Drives directed and random requests with random gaps and output stalls,
// including one long output hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_eight_bit_alu_with_flags;
  import eba_pkg::*;

  localparam logic [3:0] ModeReservedLo = 4'd10;
  localparam logic [3:0] ModeReservedHi = 4'hF;
  localparam int IdlePercent = 27;
  localparam int HoldCycles = 64;
  localparam int SettleCycles = 10;
  localparam int WatchdogLimit = 2000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [3:0] mode;
  logic [7:0] acc;
  logic [7:0] operand;
  logic       carry_in;
  logic       overflow_in;
  logic       zero_in;
  logic       negative_in;
  logic       decimal_mode;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] result;
  logic       carry_out;
  logic       overflow_out;
  logic       zero_out;
  logic       negative_out;
  logic       unsupported;
  int         fail_count;
  int         pending;
  bit         pace_on;
  bit         hold_go;
  bit         hold_done;
  int         hold_left;
  int         quiet_cycles = 0;

  eight_bit_alu_with_flags i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .acc_i          (acc),
    .operand_i      (operand),
    .carry_in_i     (carry_in),
    .overflow_in_i  (overflow_in),
    .zero_in_i      (zero_in),
    .negative_in_i  (negative_in),
    .decimal_mode_i (decimal_mode),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_o       (result),
    .carry_out_o    (carry_out),
    .overflow_out_o (overflow_out),
    .zero_out_o     (zero_out),
    .negative_out_o (negative_out),
    .unsupported_o  (unsupported)
  );

  eight_bit_alu_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .mode_i         (mode),
    .acc_i          (acc),
    .operand_i      (operand),
    .carry_in_i     (carry_in),
    .overflow_in_i  (overflow_in),
    .zero_in_i      (zero_in),
    .negative_in_i  (negative_in),
    .decimal_mode_i (decimal_mode),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .result_i       (result),
    .carry_out_i    (carry_out),
    .overflow_out_i (overflow_out),
    .zero_out_i     (zero_out),
    .negative_out_i (negative_out),
    .unsupported_i  (unsupported),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic offer(logic [3:0] op, logic [7:0] a, logic [7:0] m, logic c, logic v,
                       logic z, logic n, logic d);
    @(negedge clk);
    while (pace_on && $urandom_range(0, 99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    mode <= op;
    acc <= a;
    operand <= m;
    carry_in <= c;
    overflow_in <= v;
    zero_in <= z;
    negative_in <= n;
    decimal_mode <= d;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] corners[4];
    corners = '{8'h00, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 7) == 0) begin
      return corners[2'($urandom_range(0, 3))];
    end
    return 8'($urandom);
  endfunction

  task automatic offer_random();
    logic [3:0] op;
    if ($urandom_range(0, 99) < 6) begin
      op = 4'($urandom_range(ModeReservedLo, ModeReservedHi));
    end else begin
      op = 4'($urandom_range(MODE_ADC, MODE_ROR));
    end
    offer(op, pick_byte(), pick_byte(), 1'($urandom), 1'($urandom), 1'($urandom),
          1'($urandom), ($urandom_range(0, 3) == 0));
  endtask

  // The receiver stalls at random, and once holds off for a long stretch so
  // that both register stages fill and the request side stalls.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= pace_on && ($urandom_range(0, 99) < IdlePercent);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    mode = MODE_ADC;
    acc = 8'h00;
    operand = 8'h00;
    carry_in = 1'b0;
    overflow_in = 1'b0;
    zero_in = 1'b0;
    negative_in = 1'b0;
    decimal_mode = 1'b0;
    pace_on = 1'b1;
    hold_go = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    offer(MODE_ADC, 8'h7F, 8'h01, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    offer(MODE_ADC, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    offer(MODE_ADC, 8'h80, 8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    offer(MODE_SBC, 8'h00, 8'h01, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    offer(MODE_SBC, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    offer(MODE_SBC, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    offer(MODE_ADC, 8'h99, 8'h01, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
    offer(MODE_SBC, 8'h10, 8'h20, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
    offer(MODE_AND, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    offer(MODE_AND, 8'hF0, 8'h80, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
    offer(MODE_ORA, 8'h80, 8'h01, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    offer(MODE_EOR, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    offer(MODE_CMP, 8'h42, 8'h42, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    offer(MODE_CMP, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    offer(MODE_CMP, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    offer(MODE_ASL, 8'h12, 8'h80, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    offer(MODE_LSR, 8'h34, 8'h01, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    offer(MODE_ROL, 8'h56, 8'h80, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    offer(MODE_ROR, 8'h78, 8'h01, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    offer(MODE_ROR, 8'h9A, 8'hFE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    offer(ModeReservedLo, 8'hA5, 8'h5A, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
    offer(ModeReservedHi, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);

    repeat (450) offer_random();
    pace_on = 1'b0;
    repeat (100) offer_random();
    hold_go = 1'b1;
    repeat (200) offer_random();
    pace_on = 1'b1;
    repeat (480) offer_random();

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
